// ===== rtl/catmull_rom_polyline_smoother_top_defines.svh =====
// ----------------------------------------------------------------------------
// Catmull-Rom polyline smoother assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_POLYLINE_SMOOTHER_TOP_DEFINES_SVH
`define CATMULL_ROM_POLYLINE_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication
`define CR_ASSERT_IMP(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("catrom assertion failed");

// next-cycle implication
`define CR_ASSERT_NXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("catrom assertion failed");

`endif

// ===== rtl/catrom_pkg.sv =====
// ----------------------------------------------------------------------------
// catrom_pkg
// Types, constants and small tables shared by the polyline smoother.
// ----------------------------------------------------------------------------
package catrom_pkg;

	localparam int MAX_SUBDIVISIONS = 16;
	localparam int SUB_W            = 5;
	localparam int T_W              = 16;
	localparam int COEF_W           = 40;
	localparam int PROD_W           = COEF_W + T_W + 1;
	localparam int DIST_W           = 40;
	localparam int SUM_W            = 66;
	localparam int ROOT_W           = SUM_W / 2;
	localparam int REM_W            = ROOT_W + 2;
	localparam int CFG_IDX_W        = 2;
	localparam int JOBQ_DEPTH       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV = 2'd1;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0]  vertex_x;
		logic signed [31:0]  vertex_y;
		logic signed [31:0]  vertex_z;
		logic [DIST_W-1:0]   arc_distance;
		logic                last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} xyz_t;

	typedef enum logic {
		JOB_VERTEX,
		JOB_SEGMENT
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              last;
		logic [SUB_W-1:0]  subdiv;
		xyz_t              p0;
		xyz_t              p1;
		xyz_t              p2;
		xyz_t              p3;
	} job_t;

	typedef struct packed {
		logic             smooth;
		logic [SUB_W-1:0] subdiv;
	} cfg_t;

	typedef enum logic {
		F_IDLE,
		F_EMIT
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_ADD,
		B_SQM,
		B_SQA,
		B_SQRT,
		B_OUT
	} back_state_t;

	function automatic logic [SUB_W-1:0] clamp_subdiv(logic [SUB_W-1:0] s);
		if (s == '0)
			return SUB_W'(1);
		else if (s > SUB_W'(MAX_SUBDIVISIONS))
			return SUB_W'(MAX_SUBDIVISIONS);
		else
			return s;
	endfunction

	// floor(65536 / s)
	function automatic logic [T_W:0] recip_q(logic [SUB_W-1:0] s);
		case (s)
			5'd1:    return 17'd65536;
			5'd2:    return 17'd32768;
			5'd3:    return 17'd21845;
			5'd4:    return 17'd16384;
			5'd5:    return 17'd13107;
			5'd6:    return 17'd10922;
			5'd7:    return 17'd9362;
			5'd8:    return 17'd8192;
			5'd9:    return 17'd7281;
			5'd10:   return 17'd6553;
			5'd11:   return 17'd5957;
			5'd12:   return 17'd5461;
			5'd13:   return 17'd5041;
			5'd14:   return 17'd4681;
			5'd15:   return 17'd4369;
			default: return 17'd4096;
		endcase
	endfunction

	// 65536 mod s
	function automatic logic [3:0] recip_r(logic [SUB_W-1:0] s);
		case (s)
			5'd3:    return 4'd1;
			5'd5:    return 4'd1;
			5'd6:    return 4'd4;
			5'd7:    return 4'd2;
			5'd9:    return 4'd7;
			5'd10:   return 4'd6;
			5'd11:   return 4'd9;
			5'd12:   return 4'd4;
			5'd13:   return 4'd3;
			5'd14:   return 4'd2;
			5'd15:   return 4'd1;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] axis_sel(xyz_t p, logic [1:0] a);
		case (a)
			2'd0:    return p.x;
			2'd1:    return p.y;
			default: return p.z;
		endcase
	endfunction

endpackage

// ===== rtl/catrom_front.sv =====
// ----------------------------------------------------------------------------
// catrom_front
// Accepts control points, tracks the line and issues vertex/segment jobs.
// ----------------------------------------------------------------------------
module catrom_front import catrom_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  point_t point,
	input  logic   push,
	output logic   full,
	input  cfg_t   cfg,
	output job_t   job,
	output logic   job_push,
	input  logic   job_full
);

	front_state_t state_q, state_d;
	logic [1:0]   k_q;
	point_t       item_q;
	xyz_t         recent_q [3];
	logic [1:0]   seen_q;
	logic         smooth_q;

	point_t     cur;
	xyz_t       cx;
	logic       sm;
	logic [1:0] n;
	logic [1:0] k;
	logic       accept;
	logic       commit;

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign cur    = (state_q == F_IDLE) ? point : item_q;
	assign cx     = '{x: cur.point_x, y: cur.point_y, z: cur.point_z};
	assign sm     = (seen_q == 2'd0) ? cfg.smooth : smooth_q;
	assign k      = (state_q == F_IDLE) ? 2'd0 : k_q;

	always_comb begin
		n          = 2'd0;
		job.kind   = JOB_VERTEX;
		job.last   = 1'b0;
		job.subdiv = clamp_subdiv(cfg.subdiv);
		job.p0     = cx;
		job.p1     = cx;
		job.p2     = cx;
		job.p3     = cx;
		if (!sm) begin
			n        = 2'd1;
			job.last = cur.last_point;
		end else if (seen_q == 2'd1 && cur.last_point) begin
			n = 2'd2;
			if (k == 2'd0) begin
				job.p1 = recent_q[0];
			end else begin
				job.last = 1'b1;
			end
		end else if (seen_q == 2'd0 && cur.last_point) begin
			n        = 2'd1;
			job.last = 1'b1;
		end else if (seen_q >= 2'd2) begin
			n = cur.last_point ? 2'd3 : 2'd1;
			case (k)
				2'd0: begin
					job.kind = JOB_SEGMENT;
					job.p0   = (seen_q == 2'd2) ? recent_q[1] : recent_q[2];
					job.p1   = recent_q[1];
					job.p2   = recent_q[0];
				end
				2'd1: begin
					job.kind = JOB_SEGMENT;
					job.p0   = recent_q[1];
					job.p1   = recent_q[0];
				end
				default: begin
					job.last = 1'b1;
				end
			endcase
		end
	end

	assign job_push = (state_q == F_EMIT) && !job_full;
	assign commit   = (accept && n == 2'd0) || (job_push && k_q == n - 2'd1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && n != 2'd0)
					state_d = F_EMIT;
			end
			F_EMIT: begin
				if (commit)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			k_q      <= 2'd0;
			seen_q   <= 2'd0;
			smooth_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				recent_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				k_q <= 2'd0;
			else if (job_push)
				k_q <= k_q + 2'd1;
			if (commit) begin
				if (cur.last_point) begin
					seen_q   <= 2'd0;
					smooth_q <= 1'b0;
					for (int i = 0; i < 3; i++)
						recent_q[i] <= '0;
				end else begin
					if (seen_q == 2'd0)
						smooth_q <= cfg.smooth;
					if (seen_q != 2'd3)
						seen_q <= seen_q + 2'd1;
					recent_q[2] <= recent_q[1];
					recent_q[1] <= recent_q[0];
					recent_q[0] <= cx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= point;
	end

endmodule

// ===== rtl/catrom_jobq.sv =====
// ----------------------------------------------------------------------------
// catrom_jobq
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module catrom_jobq import catrom_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr,
	output logic full,
	output job_t rd_job,
	input  logic rd,
	output logic empty
);

	localparam int PTR_W = $clog2(JOBQ_DEPTH);

	job_t             mem_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full   = (count_q == (PTR_W+1)'(JOBQ_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr && !full)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd && !empty)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if ((wr && !full) && !(rd && !empty))
				count_q <= count_q + 1'b1;
			else if (!(wr && !full) && (rd && !empty))
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== rtl/catrom_back.sv =====
// ----------------------------------------------------------------------------
// catrom_back
// Evaluates spline samples, segment lengths and arc distance per vertex.
// ----------------------------------------------------------------------------
module catrom_back import catrom_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  job_t    job,
	input  logic    job_empty,
	output logic    job_pop,
	output vertex_t vertex,
	output logic    empty,
	input  logic    pop
);

	back_state_t state_q, state_d;

	job_t                      job_q;
	logic [3:0]                j_q;
	logic [T_W-1:0]            t_q;
	logic [3:0]                r_q;
	logic [1:0]                axis_q;
	logic [1:0]                pass_q;
	logic signed [COEF_W-1:0]  u_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [31:0]        v_q    [3];
	logic signed [31:0]        prev_q [3];
	logic [63:0]               sq_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SUM_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [5:0]                cnt_q;
	logic [DIST_W-1:0]         dist_q;
	logic                      line_start_q;
	logic                      out_valid_q;
	vertex_t                   out_q;

	logic signed [COEF_W-1:0] e0, e1, e2, e3;
	logic signed [COEF_W-1:0] ca, cb, cc, cd;
	logic signed [COEF_W-1:0] mcand, addend, u_new, vh;
	logic signed [T_W:0]      tsig;
	logic signed [PROD_W-1:0] rnd;
	logic signed [31:0]       vsat;
	logic signed [32:0]       diff;
	logic [31:0]              mag;
	logic [SUM_W-1:0]         sum_new;
	logic [REM_W+1:0]         rem_t, trial;
	logic                     ge;
	logic [DIST_W:0]          dist_sum;
	logic [DIST_W-1:0]        dist_new;
	logic                     out_free;
	logic                     more;
	logic [4:0]               rsum;
	logic                     carry;
	logic [T_W:0]             t_next;

	assign e0 = COEF_W'(axis_sel(job_q.p0, axis_q));
	assign e1 = COEF_W'(axis_sel(job_q.p1, axis_q));
	assign e2 = COEF_W'(axis_sel(job_q.p2, axis_q));
	assign e3 = COEF_W'(axis_sel(job_q.p3, axis_q));

	assign ca = e1 <<< 1;
	assign cb = e2 - e0;
	assign cc = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
	assign cd = (e1 <<< 1) + e1 - ((e2 <<< 1) + e2) + e3 - e0;

	assign tsig  = $signed({1'b0, t_q});
	assign mcand = (pass_q == 2'd0) ? cd : u_q;

	always_comb begin
		case (pass_q)
			2'd0:    addend = cc;
			2'd1:    addend = cb;
			default: addend = ca;
		endcase
	end

	assign rnd   = (prod_q + PROD_W'(32768)) >>> 16;
	assign u_new = addend + $signed(rnd[COEF_W-1:0]);
	assign vh    = (u_new + COEF_W'(1)) >>> 1;

	always_comb begin
		if (vh > COEF_W'(64'sd2147483647))
			vsat = 32'sh7fffffff;
		else if (vh < -COEF_W'(64'sd2147483648))
			vsat = 32'sh80000000;
		else
			vsat = vh[31:0];
	end

	assign diff    = line_start_q ? 33'sd0
	                 : (33'(v_q[axis_q]) - 33'(prev_q[axis_q]));
	assign mag     = diff[32] ? 32'(-diff) : diff[31:0];
	assign sum_new = ((axis_q == 2'd0) ? SUM_W'(0) : sum_q) + SUM_W'(sq_q);

	assign rem_t = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = (rem_t >= trial);

	assign dist_sum = {1'b0, dist_q} + (DIST_W+1)'(root_q);
	assign dist_new = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];

	assign out_free = !out_valid_q || pop;
	assign more     = (job_q.kind == JOB_SEGMENT) && ({1'b0, j_q} + 5'd1 < job_q.subdiv);

	assign rsum   = {1'b0, r_q} + {1'b0, recip_r(job_q.subdiv)};
	assign carry  = (rsum >= job_q.subdiv);
	assign t_next = {1'b0, t_q} + recip_q(job_q.subdiv) + (T_W+1)'(carry);

	assign job_pop = (state_q == B_IDLE) && !job_empty;
	assign empty   = !out_valid_q;
	assign vertex  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!job_empty)
					state_d = (job.kind == JOB_SEGMENT) ? B_MUL : B_SQM;
			end
			B_MUL: state_d = B_ADD;
			B_ADD: begin
				if (pass_q == 2'd2 && axis_q == 2'd2)
					state_d = B_SQM;
				else
					state_d = B_MUL;
			end
			B_SQM: state_d = B_SQA;
			B_SQA: state_d = (axis_q == 2'd2) ? B_SQRT : B_SQM;
			B_SQRT: begin
				if (cnt_q == 6'(ROOT_W - 1))
					state_d = B_OUT;
			end
			B_OUT: begin
				if (out_free)
					state_d = more ? B_MUL : B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			out_valid_q  <= 1'b0;
			line_start_q <= 1'b1;
			dist_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_OUT && out_free) begin
				out_valid_q  <= 1'b1;
				line_start_q <= job_q.last;
				dist_q       <= job_q.last ? '0 : dist_new;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q  <= job;
				j_q    <= 4'd0;
				t_q    <= '0;
				r_q    <= 4'd0;
				axis_q <= 2'd0;
				pass_q <= 2'd0;
				v_q[0] <= job.p1.x;
				v_q[1] <= job.p1.y;
				v_q[2] <= job.p1.z;
			end
			B_MUL: prod_q <= mcand * tsig;
			B_ADD: begin
				if (pass_q == 2'd2) begin
					v_q[axis_q] <= vsat;
					pass_q      <= 2'd0;
					axis_q      <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				end else begin
					u_q    <= u_new;
					pass_q <= pass_q + 2'd1;
				end
			end
			B_SQM: sq_q <= {32'b0, mag} * {32'b0, mag};
			B_SQA: begin
				sum_q <= sum_new;
				if (axis_q == 2'd2) begin
					axis_q <= 2'd0;
					rad_q  <= sum_new;
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'd0;
				end else begin
					axis_q <= axis_q + 2'd1;
				end
			end
			B_SQRT: begin
				rem_q  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
				root_q <= {root_q[ROOT_W-2:0], ge};
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q + 6'd1;
			end
			B_OUT: begin
				if (out_free) begin
					out_q.vertex_x     <= v_q[0];
					out_q.vertex_y     <= v_q[1];
					out_q.vertex_z     <= v_q[2];
					out_q.arc_distance <= dist_new;
					out_q.last_vertex  <= job_q.last;
					prev_q[0]          <= v_q[0];
					prev_q[1]          <= v_q[1];
					prev_q[2]          <= v_q[2];
					j_q                <= j_q + 4'd1;
					t_q                <= t_next[T_W-1:0];
					r_q                <= carry ? 4'(rsum - job_q.subdiv) : rsum[3:0];
					axis_q             <= 2'd0;
					pass_q             <= 2'd0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/catmull_rom_polyline_smoother_top.sv =====
// A spline sample in the back end runs the cubic on one shared multiplier, then the
// squared distance, then the square root, then the output register.
// The back end takes a new job only once it is through with the last one; the
// front takes the next point once its jobs are queued. Stalled pops hold the back end.
// Reset: arst_n clears line state, job queue, output; smoothing off, subdivisions 4.
// ----------------------------------------------------------------------------
// catmull_rom_polyline_smoother_top
// Front end, job queue, back end and configuration registers.
// ----------------------------------------------------------------------------
module catmull_rom_polyline_smoother_top import catrom_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  point_t               point,
	input  logic                 push,
	output logic                 full,
	output vertex_t              vertex,
	output logic                 empty,
	input  logic                 pop,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SUB_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	job_t front_job, queue_job;
	logic front_push, queue_full, queue_empty, back_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smooth <= 1'b0;
			cfg_q.subdiv <= SUB_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SMOOTH: cfg_q.smooth <= cfg_data[0];
				CFG_SUBDIV: cfg_q.subdiv <= cfg_data;
				default: ;
			endcase
		end
	end

	catrom_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point),
		.push     (push),
		.full     (full),
		.cfg      (cfg_q),
		.job      (front_job),
		.job_push (front_push),
		.job_full (queue_full)
	);

	catrom_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (front_job),
		.wr     (front_push),
		.full   (queue_full),
		.rd_job (queue_job),
		.rd     (back_pop),
		.empty  (queue_empty)
	);

	catrom_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_empty (queue_empty),
		.job_pop   (back_pop),
		.vertex    (vertex),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== rtl/catrom_checker.sv =====
// ----------------------------------------------------------------------------
// catrom_checker
// Port-level checks on the polyline smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "catmull_rom_polyline_smoother_top_defines.svh"

module catrom_checker import catrom_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input point_t               point,
	input logic                 push,
	input logic                 full,
	input vertex_t              vertex,
	input logic                 empty,
	input logic                 pop,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [SUB_W-1:0]     cfg_data
);

	logic              after_last_q;
	logic [DIST_W-1:0] prev_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_last_q <= 1'b1;
			prev_dist_q  <= '0;
		end else if (pop && !empty) begin
			after_last_q <= vertex.last_vertex;
			prev_dist_q  <= vertex.arc_distance;
		end
	end

	`CR_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(vertex))
	`CR_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
	`CR_ASSERT_IMP(a_line_start, !empty && after_last_q, vertex.arc_distance == '0)
	`CR_ASSERT_IMP(a_dist_mono, !empty && !after_last_q, vertex.arc_distance >= prev_dist_q)

endmodule

bind catmull_rom_polyline_smoother_top catrom_checker u_catrom_checker (.*);
